### src/ghacc_pkg.sv
package ghacc_pkg;

  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BYTES_W     = 5;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned TYPE_W      = 2;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;

  // Reduction polynomial top byte, reflected order: 1 + x + x^2 + x^7
  localparam logic [7:0] POLY_TOP = 8'he1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_AAD    = 2'd0,
    REQ_TEXT   = 2'd1,
    REQ_FINISH = 2'd2
  } req_type_e;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  // Multiply in GF(2^128) with GCM's reflected bit order: the MSB of the
  // vector is the coefficient of x^0. Carry-less product, then two folds.
  function automatic block_t gf128_mul(block_t a, block_t h);
    logic [2*BLOCK_W-2:0] prod;
    logic [BLOCK_W+5:0]   fold;
    block_t               red;
    block_t               res;
    prod = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      for (int j = 0; j < BLOCK_W; j++) begin
        prod[i+j] = prod[i+j] ^ (a[BLOCK_W-1-i] & h[BLOCK_W-1-j]);
      end
    end
    fold = {6'b0, prod[BLOCK_W-1:0]};
    for (int k = BLOCK_W; k < 2*BLOCK_W-1; k++) begin
      for (int t = 0; t < 8; t++) begin
        if (POLY_TOP[7-t]) begin
          fold[k-BLOCK_W+t] = fold[k-BLOCK_W+t] ^ prod[k];
        end
      end
    end
    red = fold[BLOCK_W-1:0];
    for (int k = BLOCK_W; k < BLOCK_W+6; k++) begin
      for (int t = 0; t < 8; t++) begin
        if (POLY_TOP[7-t]) begin
          red[k-BLOCK_W+t] = red[k-BLOCK_W+t] ^ fold[k];
        end
      end
    end
    for (int i = 0; i < BLOCK_W; i++) begin
      res[BLOCK_W-1-i] = red[i];
    end
    return res;
  endfunction

endpackage

### src/ghacc_req_if.sv
interface ghacc_req_if import ghacc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    req_type;
  logic [HALF_W-1:0]    block_high;
  logic [HALF_W-1:0]    block_low;
  logic [BYTES_W-1:0]   valid_bytes;

  modport source (
    output valid, req_type, block_high, block_low, valid_bytes,
    input  ready
  );
  modport sink (
    input  valid, req_type, block_high, block_low, valid_bytes,
    output ready
  );
endinterface

### src/ghacc_tag_if.sv
interface ghacc_tag_if import ghacc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] hash_high;
  logic [HALF_W-1:0] hash_low;

  modport source (
    output valid, hash_high, hash_low,
    input  ready
  );
  modport sink (
    input  valid, hash_high, hash_low,
    output ready
  );
endinterface

### src/ghash_accumulator_top.sv
// Channel   Direction  Payload                                        Handshake
// req_i     in         req_type, block_high, block_low, valid_bytes    valid/ready
// tag_o     out        hash_high, hash_low                            valid/ready
// APB       in/out     hash_key_high @0x0, hash_key_low @0x8 (64 bit) psel/penable
//
// One item per cycle unless the input stalls: a data request is held in the
// input register, then the GF(2^128) multiplier updates the accumulator; a
// finish then fills the tag register on tag_o once the previous tag is taken.
// Reset (rst_ni low) clears the key, accumulator, byte counts and both stages.
// Only a finish blocked by a full, unread tag register stalls the input;
// data blocks keep flowing while a tag waits to be taken.
module ghash_accumulator_top import ghacc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ghacc_req_if.sink             req_i,
  ghacc_tag_if.source           tag_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Hash key registers
  logic [HALF_W-1:0] key_high_q, key_low_q;
  cfg_reg_e          cfg_sel;
  logic              cfg_wr;

  // Input stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_finish_q;
  logic               s1_aad_q;
  block_t             s1_block_q;
  logic [BYTES_W-1:0] s1_nbytes_q;

  // Accumulator stage and result register
  block_t            acc_q;
  count_t            aad_cnt_q, text_cnt_q;
  logic              out_valid_q, out_valid_d;
  block_t            out_hash_q;

  logic               req_data, req_fin, load, s1_go, out_free;
  logic [BYTES_W-1:0] nbytes;
  block_t             byte_mask, len_block, mul_in, mul_out;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LOW:  prdata = key_low_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LOW:  key_low_q  <= pwdata;
        default:      key_high_q <= key_high_q;
      endcase
    end
  end

  // ---------------- input decode ----------------
  // Drop data items with no valid bytes and the unused request code.
  assign req_data = (req_i.req_type == REQ_AAD || req_i.req_type == REQ_TEXT)
                    && (req_i.valid_bytes != '0);
  assign req_fin  = (req_i.req_type == REQ_FINISH);
  // Clamp the byte count to one block
  assign nbytes   = (req_i.valid_bytes > BYTES_W'(BLOCK_BYTES))
                    ? BYTES_W'(BLOCK_BYTES) : req_i.valid_bytes;

  // Zero every byte past the valid count; byte 0 is the top byte.
  always_comb begin
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      byte_mask[BLOCK_W-1-8*b -: 8] = (BYTES_W'(b) < nbytes) ? 8'hff : 8'h00;
    end
  end

  // Advance the input stage unless a finish needs a busy tag register.
  assign out_free    = !out_valid_q || tag_o.ready;
  assign s1_go       = s1_valid_q && (!s1_finish_q || out_free);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign load        = req_i.valid && req_i.ready && (req_data || req_fin);

  always_comb begin
    priority if (load) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_finish_q <= req_fin;
      s1_aad_q    <= (req_i.req_type == REQ_AAD);
      s1_block_q  <= {req_i.block_high, req_i.block_low} & byte_mask;
      s1_nbytes_q <= nbytes;
    end
  end

  // ---------------- accumulate ----------------
  // Length block: AAD bit count on top, ciphertext bit count below.
  assign len_block = {aad_cnt_q, 3'b000, text_cnt_q, 3'b000};
  assign mul_in    = acc_q ^ (s1_finish_q ? len_block : s1_block_q);
  assign mul_out   = gf128_mul(mul_in, {key_high_q, key_low_q});

  always_comb begin
    priority if (s1_go && s1_finish_q) begin
      out_valid_d = 1'b1;
    end else if (tag_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      aad_cnt_q   <= '0;
      text_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        if (s1_finish_q) begin
          // Tag goes out; start the next message from scratch
          acc_q      <= '0;
          aad_cnt_q  <= '0;
          text_cnt_q <= '0;
        end else begin
          acc_q <= mul_out;
          if (s1_aad_q) begin
            aad_cnt_q <= aad_cnt_q + COUNT_W'(s1_nbytes_q);
          end else begin
            text_cnt_q <= text_cnt_q + COUNT_W'(s1_nbytes_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_finish_q) begin
      out_hash_q <= mul_out;
    end
  end

  assign tag_o.valid     = out_valid_q;
  assign tag_o.hash_high = out_hash_q[BLOCK_W-1:HALF_W];
  assign tag_o.hash_low  = out_hash_q[HALF_W-1:0];

endmodule

### src/ghacc_checker.sv
module ghacc_checker import ghacc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [TYPE_W-1:0] in_type_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [HALF_W-1:0] out_high_i,
  input logic [HALF_W-1:0] out_low_i
);

  logic fin_xfer;
  assign fin_xfer = in_valid_i && in_ready_i && (in_type_i == REQ_FINISH);

  // A fresh tag rises only when a finish transfer has passed through the input register into the tag register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(fin_xfer, 2))
    else $error("tag raised without a preceding finish transfer");

  // The input stalls only behind a tag that is waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A stalled tag holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_high_i) && $stable(out_low_i)))
    else $error("stalled tag changed or dropped");

  // The tag leaves only by a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("tag dropped without a transfer");

endmodule

bind ghash_accumulator_top ghacc_checker u_ghacc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_type_i   (req_i.req_type),
  .out_valid_i (tag_o.valid),
  .out_ready_i (tag_o.ready),
  .out_high_i  (tag_o.hash_high),
  .out_low_i   (tag_o.hash_low)
);
